// ===== hdl/itoa_pkg.sv =====
// Shared types, codes, constants and helper functions of the integer to ASCII formatter.
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int MAX_WIDTH  = 64;
  localparam int DIDX_W     = $clog2(MAX_DIGITS);
  localparam int DCNT_W     = DIDX_W + 1;

  localparam logic [2:0] OP_SDEC = 3'd0;
  localparam logic [2:0] OP_UDEC = 3'd1;
  localparam logic [2:0] OP_HEX  = 3'd2;
  localparam logic [2:0] OP_OCT  = 3'd3;
  localparam logic [2:0] OP_BIN  = 3'd4;

  localparam logic [1:0] RAD_DEC = 2'd0;
  localparam logic [1:0] RAD_HEX = 2'd1;
  localparam logic [1:0] RAD_OCT = 2'd2;
  localparam logic [1:0] RAD_BIN = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic        start;
    logic [31:0] mag;
    logic [1:0]  radix;
  } conv_req_t;

  typedef struct packed {
    logic              done;
    logic [DCNT_W-1:0] count;
  } conv_sts_t;

  function automatic logic [31:0] pow10(input logic [3:0] idx);
    logic [31:0] p;
    case (idx)
      4'd0:    p = 32'd1000000000;
      4'd1:    p = 32'd100000000;
      4'd2:    p = 32'd10000000;
      4'd3:    p = 32'd1000000;
      4'd4:    p = 32'd100000;
      4'd5:    p = 32'd10000;
      4'd6:    p = 32'd1000;
      4'd7:    p = 32'd100;
      4'd8:    p = 32'd10;
      default: p = 32'd1;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d >= 4'd10) begin
      c = CH_UPPER + {4'd0, d} - 8'd10;
    end else begin
      c = CH_ZERO + {4'd0, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter: input decode, padding plan and character output.
//
// Usage: a transaction on the input channel carries one 32-bit value with its minimum field
// width, format code, pad_after and zero_fill flags. The block answers with one transaction
// per ASCII character on the output channel, most significant character first, and marks
// the final character with out_last. A format code above binary is accepted and produces no
// characters. in_stall stays high from the accepted transaction until the last character
// has been loaded into the output register.
// Digit generation runs on a single shared 32-bit subtractor or shifter, one step
// per cycle. Decimal takes up to 10 compare steps plus one step per unit of each digit and
// one per digit; hex, octal and binary take one step per digit (up to 8, 11 or 32
// digits). Characters then leave from the output register at one per cycle while the
// receiver does not stall. A number produces at most 64 characters.
// Reset (rst_n low, synchronous) returns both sequencers to idle and empties the output
// register. While the receiver stalls, the character in the output register holds and the
// sequencer waits; nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module integer_to_ascii_formatter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_value,
  input  wire logic [6:0]  in_field_width,
  input  wire logic [2:0]  in_operation,
  input  wire logic        in_pad_after,
  input  wire logic        in_zero_fill,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char_out,
  output logic             out_last
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        neg_r, neg_nxt;
  logic                        after_r, after_nxt;
  logic [7:0]                  fill_r, fill_nxt;
  logic [6:0]                  width_r, width_nxt;
  logic [6:0]                  pad_r, pad_nxt;
  logic [itoa_pkg::DCNT_W-1:0] dig_r, dig_nxt;
  logic [6:0]                  total_r, total_nxt;
  logic [7:0]                  out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;

  itoa_pkg::conv_req_t         conv_req;
  itoa_pkg::conv_sts_t         conv_sts;
  logic [itoa_pkg::DCNT_W-1:0] dig_m1;
  logic [3:0]                  rd_digit;

  logic        accept;
  logic        neg_in;
  logic [6:0]  used;
  logic        emit_load;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign neg_in    = (in_operation == itoa_pkg::OP_SDEC) && in_value[31];
  assign used      = 7'(conv_sts.count) + 7'(neg_r);
  assign emit_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign dig_m1    = dig_r - itoa_pkg::DCNT_W'(1);

  always_comb begin
    conv_req.start = accept && (in_operation <= itoa_pkg::OP_BIN);
    if (neg_in) begin
      conv_req.mag = (in_value == 32'h8000_0000) ? 32'd0 : (32'd0 - in_value);
    end else begin
      conv_req.mag = in_value;
    end
    case (in_operation)
      itoa_pkg::OP_HEX: conv_req.radix = itoa_pkg::RAD_HEX;
      itoa_pkg::OP_OCT: conv_req.radix = itoa_pkg::RAD_OCT;
      itoa_pkg::OP_BIN: conv_req.radix = itoa_pkg::RAD_BIN;
      default:          conv_req.radix = itoa_pkg::RAD_DEC;
    endcase
  end

  itoa_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (conv_req),
    .sts      (conv_sts),
    .rd_addr  (dig_m1[itoa_pkg::DIDX_W-1:0]),
    .rd_digit (rd_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    neg_nxt       = neg_r;
    after_nxt     = after_r;
    fill_nxt      = fill_r;
    width_nxt     = width_r;
    pad_nxt       = pad_r;
    dig_nxt       = dig_r;
    total_nxt     = total_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (conv_req.start) begin
          neg_nxt   = neg_in;
          after_nxt = in_pad_after;
          fill_nxt  = in_zero_fill ? itoa_pkg::CH_ZERO : itoa_pkg::CH_SPACE;
          width_nxt = (in_field_width > 7'(itoa_pkg::MAX_WIDTH)) ?
                      7'(itoa_pkg::MAX_WIDTH) : in_field_width;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (conv_sts.done) begin
          dig_nxt = conv_sts.count;
          if (width_r > used) begin
            pad_nxt   = width_r - used;
            total_nxt = width_r;
          end else begin
            pad_nxt   = '0;
            total_nxt = used;
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (total_r == 7'd1);
          total_nxt     = total_r - 7'd1;
          if (!after_r && pad_r != 7'd0) begin
            out_char_nxt = fill_r;
            pad_nxt      = pad_r - 7'd1;
          end else if (neg_r) begin
            out_char_nxt = itoa_pkg::CH_MINUS;
            neg_nxt      = 1'b0;
          end else if (dig_r != '0) begin
            out_char_nxt = itoa_pkg::digit_char(rd_digit);
            dig_nxt      = dig_m1;
          end else begin
            out_char_nxt = itoa_pkg::CH_SPACE;
            pad_nxt      = pad_r - 7'd1;
          end
          if (total_r == 7'd1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    after_r    <= after_nxt;
    fill_r     <= fill_nxt;
    width_r    <= width_nxt;
    pad_r      <= pad_nxt;
    dig_r      <= dig_nxt;
    total_r    <= total_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_char_out = out_char_r;
  assign out_last     = out_last_r;

  a_done_in_conv : assert property (@(posedge clk) disable iff (!rst_n)
    conv_sts.done |-> state_r == S_CONV)
    else $error("Digit generator finished outside the conversion phase.");

  a_total_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> (total_r != 7'd0 && total_r <= 7'(itoa_pkg::MAX_WIDTH)))
    else $error("Remaining character count out of range while emitting.");

  a_last_to_idle : assert property (@(posedge clk) disable iff (!rst_n)
    (emit_load && total_r == 7'd1) |=> (state_r == S_IDLE && out_valid && out_last))
    else $error("Final character did not close the transaction sequence.");

  a_no_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !conv_req.start)
    else $error("Conversion started while the block was busy.");

endmodule

`default_nettype wire

// ===== hdl/itoa_conv.sv =====
// Digit generator: one shared subtractor and shifter under a small sequencer, with the digit store.
`timescale 1ns / 1ps
`default_nettype none

module itoa_conv (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire itoa_pkg::conv_req_t         req,
  output itoa_pkg::conv_sts_t              sts,
  input  wire logic [itoa_pkg::DIDX_W-1:0] rd_addr,
  output logic [3:0]                       rd_digit
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_SCAN = 2'd1;
  localparam logic [1:0] C_DEC  = 2'd2;
  localparam logic [1:0] C_P2   = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic                        done_r, done_nxt;
  logic [31:0]                 mag_r, mag_nxt;
  logic [1:0]                  radix_r, radix_nxt;
  logic [3:0]                  idx_r, idx_nxt;
  logic [3:0]                  dig_r, dig_nxt;
  logic [itoa_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;

  logic [3:0]                  store_r [itoa_pkg::MAX_DIGITS];
  logic                        we;
  logic [itoa_pkg::DIDX_W-1:0] waddr;
  logic [3:0]                  wdata;

  logic [32:0] sub;
  logic        borrow;
  logic [31:0] shifted;
  logic [3:0]  digit_p2;

  assign sub    = {1'b0, mag_r} - {1'b0, itoa_pkg::pow10(idx_r)};
  assign borrow = sub[32];

  always_comb begin
    case (radix_r)
      itoa_pkg::RAD_HEX: begin
        shifted  = mag_r >> 4;
        digit_p2 = mag_r[3:0];
      end
      itoa_pkg::RAD_OCT: begin
        shifted  = mag_r >> 3;
        digit_p2 = {1'b0, mag_r[2:0]};
      end
      default: begin
        shifted  = mag_r >> 1;
        digit_p2 = {3'd0, mag_r[0]};
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    mag_nxt   = mag_r;
    radix_nxt = radix_r;
    idx_nxt   = idx_r;
    dig_nxt   = dig_r;
    cnt_nxt   = cnt_r;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    case (state_r)
      C_IDLE: begin
        if (req.start) begin
          mag_nxt   = req.mag;
          radix_nxt = req.radix;
          idx_nxt   = '0;
          dig_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = (req.radix == itoa_pkg::RAD_DEC) ? C_SCAN : C_P2;
        end
      end
      C_SCAN: begin
        if (idx_r < 4'd9 && borrow) begin
          idx_nxt = idx_r + 4'd1;
        end else begin
          cnt_nxt   = itoa_pkg::DCNT_W'(10) - itoa_pkg::DCNT_W'(idx_r);
          state_nxt = C_DEC;
        end
      end
      C_DEC: begin
        if (!borrow) begin
          mag_nxt = sub[31:0];
          dig_nxt = dig_r + 4'd1;
        end else begin
          we      = 1'b1;
          waddr   = itoa_pkg::DIDX_W'(4'd9 - idx_r);
          wdata   = dig_r;
          dig_nxt = '0;
          if (idx_r == 4'd9) begin
            state_nxt = C_IDLE;
            done_nxt  = 1'b1;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
      end
      default: begin
        we      = 1'b1;
        waddr   = cnt_r[itoa_pkg::DIDX_W-1:0];
        wdata   = digit_p2;
        mag_nxt = shifted;
        cnt_nxt = cnt_r + itoa_pkg::DCNT_W'(1);
        if (shifted == 32'd0 || cnt_r == itoa_pkg::DCNT_W'(itoa_pkg::MAX_DIGITS - 1)) begin
          state_nxt = C_IDLE;
          done_nxt  = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    radix_r <= radix_nxt;
    idx_r   <= idx_nxt;
    dig_r   <= dig_nxt;
    cnt_r   <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  assign sts.done  = done_r;
  assign sts.count = cnt_r;
  assign rd_digit  = store_r[rd_addr];

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the integer to ASCII formatter unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 200;

  localparam logic [2:0] OP_UNUSED_5 = 3'd5;
  localparam logic [2:0] OP_UNUSED_6 = 3'd6;
  localparam logic [2:0] OP_UNUSED_7 = 3'd7;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  class itoa_char_scoreboard;
    typedef struct packed {
      logic [7:0] code;
      logic       last;
    } char_t;

    char_t expected_chars[$];
    int    mismatch_count;

    function new();
      mismatch_count = 0;
    endfunction

    function void note_number(input logic [31:0] value, input logic [6:0] field_width,
                              input logic [2:0] operation, input logic pad_after,
                              input logic zero_fill);
      logic [3:0]  digits[$];
      logic [7:0]  text[$];
      logic [31:0] mag;
      logic        neg;
      logic [7:0]  fill;
      int          width;
      int          used;
      int          pad;
      int          shift;
      char_t       entry;
      if (operation > itoa_pkg::OP_BIN) begin
        return;
      end
      width = (field_width > itoa_pkg::MAX_WIDTH) ? itoa_pkg::MAX_WIDTH : int'(field_width);
      neg = (operation == itoa_pkg::OP_SDEC) && value[31];
      mag = value;
      if (neg) begin
        mag = (value == 32'h8000_0000) ? 32'd0 : -value;
      end
      if (operation == itoa_pkg::OP_SDEC || operation == itoa_pkg::OP_UDEC) begin
        do begin
          digits.push_front(4'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
      end else begin
        shift = (operation == itoa_pkg::OP_HEX) ? 4 : (operation == itoa_pkg::OP_OCT) ? 3 : 1;
        do begin
          digits.push_front(4'(mag & ((32'd1 << shift) - 1)));
          mag = mag >> shift;
        end while (mag != 0);
      end
      used = digits.size() + int'(neg);
      pad = (width > used) ? width - used : 0;
      fill = zero_fill ? CHAR_ZERO : CHAR_SPACE;
      if (!pad_after) begin
        repeat (pad) text.push_back(fill);
      end
      if (neg) begin
        text.push_back(CHAR_MINUS);
      end
      foreach (digits[i]) begin
        text.push_back((digits[i] >= 4'd10) ? 8'(CHAR_A + digits[i] - 10)
                                            : 8'(CHAR_ZERO + digits[i]));
      end
      if (pad_after) begin
        repeat (pad) text.push_back(CHAR_SPACE);
      end
      foreach (text[i]) begin
        entry.code = text[i];
        entry.last = (i == text.size() - 1);
        expected_chars.push_back(entry);
      end
    endfunction

    function void check_char(input logic [7:0] code, input logic last);
      char_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character 0x%02h (last %0b) with no number pending", code, last);
        mismatch_count++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $error("char_out: expected 0x%02h, got 0x%02h", want.code, code);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic [31:0] in_value       = '0;
  logic [6:0]  in_field_width = '0;
  logic [2:0]  in_operation   = itoa_pkg::OP_SDEC;
  logic        in_pad_after   = 1'b0;
  logic        in_zero_fill   = 1'b0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_char_out;
  logic        out_last;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count   = 0;

  itoa_char_scoreboard sb;

  integer_to_ascii_formatter_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .in_operation   (in_operation),
    .in_pad_after   (in_pad_after),
    .in_zero_fill   (in_zero_fill),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_char_out   (out_char_out),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      sb.check_char(out_char_out, out_last);
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_number(input logic [31:0] value, input logic [6:0] field_width,
                             input logic [2:0] operation, input logic pad_after,
                             input logic zero_fill);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_field_width <= field_width;
    in_operation   <= operation;
    in_pad_after   <= pad_after;
    in_zero_fill   <= zero_fill;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_number(value, field_width, operation, pad_after, zero_fill);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1000);
      2: return $urandom() >> $urandom_range(31);
      3: return 32'h8000_0000 + $urandom_range(8) - 4;
      4: begin
        repeat ($urandom_range(9)) p = p * 10;
        return p + $urandom_range(2) - 1;
      end
      default: return 32'hFFFF_FFFF - $urandom_range(20);
    endcase
  endfunction

  task automatic random_numbers(input int count);
    logic [2:0] op;
    logic [6:0] width;
    int         sent;
    sent = 0;
    while (sent < count) begin
      op = ($urandom_range(24) == 0) ? 3'($urandom_range(OP_UNUSED_7, OP_UNUSED_5))
                                     : 3'($urandom_range(itoa_pkg::OP_BIN));
      width = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(24));
      send_number(pick_value(), width, op, 1'($urandom_range(1)), 1'($urandom_range(1)));
      if (op <= itoa_pkg::OP_BIN) begin
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 17;
    recv_idle_pct <= 50;

    send_number(32'd0,          7'd0,   itoa_pkg::OP_SDEC, 1'b0, 1'b0);
    send_number(32'h8000_0000,  7'd0,   itoa_pkg::OP_SDEC, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF,  7'd0,   itoa_pkg::OP_SDEC, 1'b0, 1'b0);
    send_number(32'h7FFF_FFFF,  7'd12,  itoa_pkg::OP_SDEC, 1'b0, 1'b1);
    send_number(32'hFFFF_FFFB,  7'd8,   itoa_pkg::OP_SDEC, 1'b0, 1'b1);
    send_number(32'hFFFF_FFFB,  7'd8,   itoa_pkg::OP_SDEC, 1'b1, 1'b1);
    send_number(32'h8000_0000,  7'd6,   itoa_pkg::OP_SDEC, 1'b0, 1'b0);
    send_number(32'hFFFF_FFFF,  7'd0,   itoa_pkg::OP_UDEC, 1'b0, 1'b0);
    send_number(32'd1000000000, 7'd0,   itoa_pkg::OP_UDEC, 1'b0, 1'b0);
    send_number(32'd999999999,  7'd3,   itoa_pkg::OP_UDEC, 1'b0, 1'b1);
    send_number(32'd10,         7'd1,   itoa_pkg::OP_UDEC, 1'b1, 1'b0);
    send_number(32'hFFFF_FFFF,  7'd0,   itoa_pkg::OP_HEX,  1'b0, 1'b0);
    send_number(32'hABCD_EF01,  7'd10,  itoa_pkg::OP_HEX,  1'b1, 1'b1);
    send_number(32'h0FFF_FFFF,  7'd64,  itoa_pkg::OP_HEX,  1'b0, 1'b1);
    send_number(32'hFFFF_FFFF,  7'd0,   itoa_pkg::OP_OCT,  1'b0, 1'b0);
    send_number(32'h1FFF_FFFF,  7'd65,  itoa_pkg::OP_OCT,  1'b0, 1'b0);
    send_number(32'd0,          7'd5,   itoa_pkg::OP_OCT,  1'b1, 1'b0);
    send_number(32'hFFFF_FFFF,  7'd64,  itoa_pkg::OP_BIN,  1'b0, 1'b1);
    send_number(32'h8000_0000,  7'd127, itoa_pkg::OP_BIN,  1'b1, 1'b1);
    send_number(32'd0,          7'd0,   itoa_pkg::OP_BIN,  1'b0, 1'b0);
    send_number(32'h1234_5678,  7'd20,  OP_UNUSED_5,       1'b0, 1'b1);
    send_number(32'hFFFF_FFFF,  7'd127, OP_UNUSED_6,       1'b1, 1'b0);
    send_number(32'd7,          7'd3,   OP_UNUSED_7,       1'b1, 1'b1);
    send_number(32'd42,         7'd4,   itoa_pkg::OP_UDEC, 1'b0, 1'b0);

    random_numbers(105);
    send_idle_pct = 50;
    recv_idle_pct <= 17;
    random_numbers(110);
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    random_numbers(110);
    in_valid <= 1'b0;

    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
